>>> design/emrs_pkg.sv
// ----------------------------------------------------------------------------
// emrs_pkg
// Shared types, constants and helpers of the energy meter reading scaler.
// ----------------------------------------------------------------------------
package emrs_pkg;

    // Field widths
    localparam int RAW_W    = 24;
    localparam int PERIOD_W = 16;
    localparam int COEF_W   = 32;
    localparam int PROD_W   = RAW_W + COEF_W;   // 56, exact product width
    localparam int SUM_W    = PROD_W + 1;       // product plus offset headroom
    localparam int MAG_W    = PROD_W - 1;       // |energy * scale| <= 2^54
    localparam int POWER_W  = 40;
    localparam int DIV_STEPS = MAG_W;           // one quotient bit per stage

    // Raw voltage at or above this selects the high gain/offset pair
    localparam logic [RAW_W-1:0] VOLTAGE_KNEE = 24'd564590;

    // Configuration register file
    localparam int NUM_CFG   = 8;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CURRENT_GAIN        = 3'd0,
        CFG_CURRENT_OFFSET      = 3'd1,
        CFG_VOLTAGE_GAIN_LOW    = 3'd2,
        CFG_VOLTAGE_OFFSET_LOW  = 3'd3,
        CFG_VOLTAGE_GAIN_HIGH   = 3'd4,
        CFG_VOLTAGE_OFFSET_HIGH = 3'd5,
        CFG_POWER_SCALE         = 3'd6,
        CFG_POWER_OFFSET        = 3'd7
    } cfg_idx_e;

    localparam logic [COEF_W-1:0] CFG_RESET [NUM_CFG] = '{
        32'd65536, 32'd0, 32'd65536, 32'd0,
        32'd65536, 32'd0, 32'd65536, 32'd0
    };

    // Data that rides alongside the divider
    typedef struct packed {
        logic [COEF_W-1:0] current;
        logic [COEF_W-1:0] voltage;
        logic              neg;
        logic              nonzero;
        logic              pzero;
    } side_t;

    // One divider stage: partial remainder, dividend/quotient shift word
    typedef struct packed {
        logic [PERIOD_W-1:0] rem;
        logic [MAG_W-1:0]    word;
        logic [PERIOD_W-1:0] divisor;
        side_t               side;
    } div_stage_t;

    // One finished result
    typedef struct packed {
        logic [COEF_W-1:0]         current;
        logic [COEF_W-1:0]         voltage;
        logic signed [POWER_W-1:0] power;
        logic                      pzero;
    } result_t;

    // Clamp a signed sum into 0 .. 2^32-1
    function automatic logic [COEF_W-1:0] sat_u32(input logic signed [SUM_W-1:0] x);
        logic [COEF_W-1:0] r;
        if (x[SUM_W-1])
            r = '0;
        else if (|x[SUM_W-2:COEF_W])
            r = '1;
        else
            r = x[COEF_W-1:0];
        return r;
    endfunction

    // Saturate a signed sum into the 40 bit signed range
    function automatic logic signed [POWER_W-1:0] sat_s40(
        input logic signed [SUM_W-1:0] x
    );
        logic signed [POWER_W-1:0] r;
        if (&x[SUM_W-1:POWER_W-1] || ~|x[SUM_W-1:POWER_W-1])
            r = x[POWER_W-1:0];
        else if (x[SUM_W-1])
            r = {1'b1, {(POWER_W-1){1'b0}}};
        else
            r = {1'b0, {(POWER_W-1){1'b1}}};
        return r;
    endfunction

endpackage

>>> design/emrs_div.sv
// ----------------------------------------------------------------------------
// emrs_div
// Pipelined restoring divider: 55 bit unsigned dividend by 16 bit divisor,
// one quotient bit per stage, with sideband data carried alongside.
// ----------------------------------------------------------------------------
module emrs_div
    import emrs_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [MAG_W-1:0]    dividend,
    input  logic [PERIOD_W-1:0] divisor,
    input  side_t               in_side,
    output logic                out_valid,
    output logic [MAG_W-1:0]    quotient,
    output side_t               out_side
);

    div_stage_t             stg_reg  [DIV_STEPS];
    div_stage_t             stg_next [DIV_STEPS];
    div_stage_t             src_c    [DIV_STEPS];
    logic [DIV_STEPS-1:0]   vld_reg;

    // Stage 0 starts from a zero remainder
    assign src_c[0] = '{rem: '0, word: dividend, divisor: divisor, side: in_side};

    genvar k;
    generate
        for (k = 0; k < DIV_STEPS; k++)
        begin : g_step
            logic [PERIOD_W:0] trial;
            logic [PERIOD_W:0] diff;
            logic              ge;

            if (k > 0)
            begin : g_link
                assign src_c[k] = stg_reg[k-1];
            end

            // Shift in the next dividend bit, subtract when it fits
            assign trial = {src_c[k].rem, src_c[k].word[MAG_W-1]};
            assign diff  = trial - {1'b0, src_c[k].divisor};
            assign ge    = (trial >= {1'b0, src_c[k].divisor});

            always_comb
            begin
                stg_next[k]         = src_c[k];
                stg_next[k].rem     = ge ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
                stg_next[k].word    = {src_c[k].word[MAG_W-2:0], ge};
            end

            // Stage payload
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    stg_reg[k] <= stg_next[k];
                end
            end
        end
    endgenerate

    // Valid bits travel with the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DIV_STEPS-2:0], in_valid};
        end
    end

    assign out_valid = vld_reg[DIV_STEPS-1];
    assign quotient  = stg_reg[DIV_STEPS-1].word;
    assign out_side  = stg_reg[DIV_STEPS-1].side;

    // Final remainder is always below a nonzero divisor
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (stg_reg[DIV_STEPS-1].divisor != '0)
        |-> (stg_reg[DIV_STEPS-1].rem < stg_reg[DIV_STEPS-1].divisor))
        else $error("divider remainder not below divisor");

    // A held pipeline keeps its last stage
    a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(out_valid))
        else $error("divider output valid moved while held");

    // An entering transaction occupies the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        en && in_valid |=> vld_reg[0])
        else $error("divider dropped an entering transaction");

endmodule

>>> design/energy_meter_reading_scaler.sv
// ----------------------------------------------------------------------------
// energy_meter_reading_scaler
// Scales one metering reading into Q16.16 current and voltage and Q24.16
// active power (signed energy times scale over line period plus offset).
// ----------------------------------------------------------------------------
//
//  chan | handshake             | payload
//  -----+-----------------------+-----------------------------------------------------------
//  in   | in_valid / in_ready   | raw_current_rms, raw_voltage_rms, line_period, raw_energy
//  out  | out_valid / out_ready | current_value, voltage_value, power_value, period_zero
//  cfg  | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  One transaction per cycle sustained while the skid entry is free. From acceptance
//  to out_valid: product, offset/abs, 55 divider stages (one quotient bit each),
//  sign, then the output register.
//  Reset clears all valid bits and loads the register defaults; no clearing
//  pass. cfg_ready is always high.
//  A result waiting on out_ready parks in a one-entry skid stage; the pipeline
//  and in_ready stall only while that skid entry is full.
//
module energy_meter_reading_scaler
    import emrs_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    // reading input
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [RAW_W-1:0]           raw_current_rms,
    input  logic [RAW_W-1:0]           raw_voltage_rms,
    input  logic [PERIOD_W-1:0]        line_period,
    input  logic [RAW_W-1:0]           raw_energy,
    // result output
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [COEF_W-1:0]          current_value,
    output logic [COEF_W-1:0]          voltage_value,
    output logic signed [POWER_W-1:0]  power_value,
    output logic                       period_zero,
    // configuration writes
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [COEF_W-1:0]          cfg_data
);

    logic [COEF_W-1:0] cfg_reg [NUM_CFG];

    logic adv;

    // stage 1
    logic                      p1_vld_reg;
    logic [PROD_W-1:0]         p1_cur_reg;
    logic [PROD_W-1:0]         p1_vol_reg;
    logic                      p1_vol_hi_reg;
    logic signed [PROD_W-1:0]  p1_pow_reg;
    logic                      p1_nonzero_reg;
    logic                      p1_pzero_reg;
    logic [PERIOD_W-1:0]       p1_period_reg;

    // stage 2
    logic                      p2_vld_reg;
    logic [MAG_W-1:0]          p2_mag_reg;
    logic [PERIOD_W-1:0]       p2_period_reg;
    side_t                     p2_side_reg;

    // divider output and stage 3
    logic                      div_vld;
    logic [MAG_W-1:0]          div_q;
    side_t                     div_side;
    logic                      p3_vld_reg;
    logic signed [PROD_W-1:0]  p3_q_reg;
    side_t                     p3_side_reg;

    // output register and skid
    result_t                   res_c;
    result_t                   out_reg;
    result_t                   out_next;
    result_t                   skid_reg;
    logic                      out_vld_reg;
    logic                      out_vld_next;
    logic                      skid_vld_reg;
    logic                      skid_vld_next;
    logic                      out_load;
    logic                      skid_load;

    // ------------------------------------------------------------------
    // Configuration register file
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CFG; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // Pipeline moves whenever the skid entry is free
    assign adv      = !skid_vld_reg;
    assign in_ready = adv;

    // ------------------------------------------------------------------
    // Stage 1: the three products
    // ------------------------------------------------------------------
    logic                      nonzero_c;
    logic [RAW_W-1:0]          cur_raw_c;
    logic                      vol_hi_c;
    logic [COEF_W-1:0]         vol_gain_c;
    logic [PROD_W-1:0]         cur_prod_c;
    logic [PROD_W-1:0]         vol_prod_c;
    logic signed [PROD_W-1:0]  pow_prod_c;

    assign nonzero_c  = |raw_energy;
    assign cur_raw_c  = nonzero_c ? raw_current_rms : '0;
    assign vol_hi_c   = (raw_voltage_rms >= VOLTAGE_KNEE);
    assign vol_gain_c = vol_hi_c ? cfg_reg[CFG_VOLTAGE_GAIN_HIGH]
                                 : cfg_reg[CFG_VOLTAGE_GAIN_LOW];
    assign cur_prod_c = {{COEF_W{1'b0}}, cur_raw_c}
                      * {{RAW_W{1'b0}}, cfg_reg[CFG_CURRENT_GAIN]};
    assign vol_prod_c = {{COEF_W{1'b0}}, raw_voltage_rms}
                      * {{RAW_W{1'b0}}, vol_gain_c};
    assign pow_prod_c = $signed({{COEF_W{raw_energy[RAW_W-1]}}, raw_energy})
                      * $signed({{RAW_W{cfg_reg[CFG_POWER_SCALE][COEF_W-1]}},
                                 cfg_reg[CFG_POWER_SCALE]});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_cur_reg     <= cur_prod_c;
            p1_vol_reg     <= vol_prod_c;
            p1_vol_hi_reg  <= vol_hi_c;
            p1_pow_reg     <= pow_prod_c;
            p1_nonzero_reg <= nonzero_c;
            p1_pzero_reg   <= (line_period == '0);
            p1_period_reg  <= line_period;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: offsets and clamps, power magnitude
    // ------------------------------------------------------------------
    logic [COEF_W-1:0]         cur_off_c;
    logic [COEF_W-1:0]         vol_off_c;
    logic signed [SUM_W-1:0]   cur_sum_c;
    logic signed [SUM_W-1:0]   vol_sum_c;
    logic [PROD_W-1:0]         pow_abs_c;
    side_t                     p2_side_c;

    assign cur_off_c = p1_nonzero_reg ? cfg_reg[CFG_CURRENT_OFFSET] : '0;
    assign vol_off_c = p1_vol_hi_reg ? cfg_reg[CFG_VOLTAGE_OFFSET_HIGH]
                                     : cfg_reg[CFG_VOLTAGE_OFFSET_LOW];
    assign cur_sum_c = $signed({1'b0, p1_cur_reg})
                     + $signed({{(SUM_W-COEF_W){cur_off_c[COEF_W-1]}}, cur_off_c});
    assign vol_sum_c = $signed({1'b0, p1_vol_reg})
                     + $signed({{(SUM_W-COEF_W){vol_off_c[COEF_W-1]}}, vol_off_c});
    assign pow_abs_c = p1_pow_reg[PROD_W-1] ? PROD_W'(-p1_pow_reg) : p1_pow_reg;

    always_comb
    begin
        p2_side_c.current = sat_u32(cur_sum_c);
        p2_side_c.voltage = sat_u32(vol_sum_c);
        p2_side_c.neg     = p1_pow_reg[PROD_W-1];
        p2_side_c.nonzero = p1_nonzero_reg;
        p2_side_c.pzero   = p1_pzero_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_mag_reg    <= pow_abs_c[MAG_W-1:0];
            p2_period_reg <= p1_period_reg;
            p2_side_reg   <= p2_side_c;
        end
    end

    // ------------------------------------------------------------------
    // Divider: |energy * scale| / period
    // ------------------------------------------------------------------
    emrs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (p2_vld_reg),
        .dividend  (p2_mag_reg),
        .divisor   (p2_period_reg),
        .in_side   (p2_side_reg),
        .out_valid (div_vld),
        .quotient  (div_q),
        .out_side  (div_side)
    );

    // ------------------------------------------------------------------
    // Stage 3: restore the sign (truncation toward zero)
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p3_q_reg    <= div_side.neg ? PROD_W'(-$signed({1'b0, div_q}))
                                        : $signed({1'b0, div_q});
            p3_side_reg <= div_side;
        end
    end

    // Power offset, saturation and the zero period case
    logic [COEF_W-1:0]         pow_off_c;
    logic signed [SUM_W-1:0]   pow_sum_c;

    assign pow_off_c = p3_side_reg.nonzero ? cfg_reg[CFG_POWER_OFFSET] : '0;
    assign pow_sum_c = $signed({p3_q_reg[PROD_W-1], p3_q_reg})
                     + $signed({{(SUM_W-COEF_W){pow_off_c[COEF_W-1]}}, pow_off_c});

    always_comb
    begin
        res_c.current = p3_side_reg.current;
        res_c.voltage = p3_side_reg.voltage;
        res_c.power   = p3_side_reg.pzero ? '0 : sat_s40(pow_sum_c);
        res_c.pzero   = p3_side_reg.pzero;
    end

    // Valid bits of the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_vld_reg <= in_valid;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= div_vld;
        end
    end

    // ------------------------------------------------------------------
    // Output register with one-entry skid
    // ------------------------------------------------------------------
    always_comb
    begin
        out_vld_next  = out_vld_reg;
        skid_vld_next = skid_vld_reg;
        out_next      = res_c;
        out_load      = 1'b0;
        skid_load     = 1'b0;
        if (!out_vld_reg || out_ready)
        begin
            out_load = 1'b1;
            if (skid_vld_reg)
            begin
                out_next      = skid_reg;
                out_vld_next  = 1'b1;
                skid_vld_next = 1'b0;
            end
            else
            begin
                out_vld_next = p3_vld_reg;
            end
        end
        else if (adv && p3_vld_reg)
        begin
            skid_load     = 1'b1;
            skid_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg <= out_next;
        end
        if (skid_load)
        begin
            skid_reg <= res_c;
        end
    end

    assign out_valid     = out_vld_reg;
    assign current_value = out_reg.current;
    assign voltage_value = out_reg.voltage;
    assign power_value   = out_reg.power;
    assign period_zero   = out_reg.pzero;

    // Skid entry is only used behind an occupied output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid entry valid with empty output register");

    // A stalled input side means a result is on offer
    a_stall_has_result: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled without a pending result");

    // Zero period always reports zero power
    a_pzero_power: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && period_zero |-> (power_value == '0))
        else $error("nonzero power with zero line period");

endmodule

>>> dv/energy_meter_reading_scaler_tb.sv
// ----------------------------------------------------------------------------
// energy_meter_reading_scaler_tb
// Self-checking bench for the reading scaler. Readings are driven through the
// valid/ready input, and every accepted reading is predicted from a local
// copy of the coefficient registers. Results are checked field by field in
// order. The coefficient settings change between phases while the block is
// idle, and back-pressure on both sides varies from phase to phase.
// ----------------------------------------------------------------------------
module energy_meter_reading_scaler_tb;
    import emrs_pkg::*;

    localparam int  READINGS_PER_PHASE = 150;
    localparam int  RANDOM_PHASES      = 9;
    localparam int  STALL_LIMIT        = 4000;
    localparam int  DRAIN_CYCLES       = 70;
    localparam int  MAX_REPORTS        = 10;
    localparam longint POWER_MAX       = 64'sh0000_007F_FFFF_FFFF;
    localparam longint POWER_MIN       = -POWER_MAX - 1;

    typedef enum int {STYLE_RESET, STYLE_MAX, STYLE_MIN, STYLE_RANDOM} setting_style_e;

    typedef struct packed {
        logic [RAW_W-1:0]    irms;
        logic [RAW_W-1:0]    vrms;
        logic [PERIOD_W-1:0] period;
        logic [RAW_W-1:0]    eraw;
    } reading_t;

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [RAW_W-1:0]          raw_current_rms = '0;
    logic [RAW_W-1:0]          raw_voltage_rms = '0;
    logic [PERIOD_W-1:0]       line_period = '0;
    logic [RAW_W-1:0]          raw_energy = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [COEF_W-1:0]         current_value;
    logic [COEF_W-1:0]         voltage_value;
    logic signed [POWER_W-1:0] power_value;
    logic                      period_zero;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [COEF_W-1:0]         cfg_data = '0;

    // Local copy of the coefficient registers
    logic [COEF_W-1:0] cfg_model [NUM_CFG];

    reading_t reading_q [$];
    result_t  expected_q [$];
    reading_t drive_item;
    bit       in_taken = 1'b0;
    int       readings_queued = 0;
    int       readings_accepted = 0;
    int       mismatch_count = 0;
    int       stall_cycles = 0;
    int       sender_idle_pct = 0;
    int       receiver_idle_pct = 0;

    energy_meter_reading_scaler u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .raw_current_rms (raw_current_rms),
        .raw_voltage_rms (raw_voltage_rms),
        .line_period     (line_period),
        .raw_energy      (raw_energy),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .current_value   (current_value),
        .voltage_value   (voltage_value),
        .power_value     (power_value),
        .period_zero     (period_zero),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Gain times raw plus optional offset, clamped into 0 .. 2^32-1
    function automatic logic [COEF_W-1:0] apply_gain(
        input logic [RAW_W-1:0]  raw,
        input logic [COEF_W-1:0] gain,
        input logic [COEF_W-1:0] offset,
        input bit                with_offset
    );
        longint acc;
        acc = longint'(raw) * longint'(gain);
        if (with_offset)
            acc += longint'($signed(offset));
        if (acc < 0)
            return '0;
        if (acc > longint'(64'h0000_0000_FFFF_FFFF))
            return '1;
        return acc[COEF_W-1:0];
    endfunction

    // Expected result of one reading under the current register copy
    function automatic result_t predict_reading(
        input logic [RAW_W-1:0]    irms,
        input logic [RAW_W-1:0]    vrms,
        input logic [PERIOD_W-1:0] period,
        input logic [RAW_W-1:0]    eraw
    );
        longint  energy;
        longint  quot;
        bit      nonzero;
        result_t r;
        energy  = longint'($signed(eraw));
        nonzero = (energy != 0);
        // zero energy forces the current to zero and drops its offset
        r.current = apply_gain(nonzero ? irms : '0, cfg_model[CFG_CURRENT_GAIN],
                               cfg_model[CFG_CURRENT_OFFSET], nonzero);
        if (vrms < VOLTAGE_KNEE)
            r.voltage = apply_gain(vrms, cfg_model[CFG_VOLTAGE_GAIN_LOW],
                                   cfg_model[CFG_VOLTAGE_OFFSET_LOW], 1'b1);
        else
            r.voltage = apply_gain(vrms, cfg_model[CFG_VOLTAGE_GAIN_HIGH],
                                   cfg_model[CFG_VOLTAGE_OFFSET_HIGH], 1'b1);
        r.pzero = (period == '0);
        if (r.pzero)
        begin
            r.power = '0;
        end
        else
        begin
            // signed division truncates toward zero
            quot = energy * longint'($signed(cfg_model[CFG_POWER_SCALE]))
                   / longint'(period);
            if (nonzero)
                quot += longint'($signed(cfg_model[CFG_POWER_OFFSET]));
            if (quot > POWER_MAX)
                quot = POWER_MAX;
            if (quot < POWER_MIN)
                quot = POWER_MIN;
            r.power = quot[POWER_W-1:0];
        end
        return r;
    endfunction

    task automatic note_mismatch(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%s mismatch: expected %h, got %h", field, want, got);
    endtask

    // Input driver: next reading goes out at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            in_taken = 1'b0;
            if (reading_q.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
            begin
                drive_item = reading_q.pop_front();
                in_valid        <= 1'b1;
                raw_current_rms <= drive_item.irms;
                raw_voltage_rms <= drive_item.vrms;
                line_period     <= drive_item.period;
                raw_energy      <= drive_item.eraw;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result back-pressure
    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);

    // Monitor: predict on input transactions, check on output transactions
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_q.push_back(predict_reading(raw_current_rms, raw_voltage_rms,
                                                     line_period, raw_energy));
                in_taken = 1'b1;
                readings_accepted++;
            end
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("result with no reading outstanding: %h %h %h %b",
                                 current_value, voltage_value, power_value, period_zero);
                end
                else
                begin
                    result_t want;
                    want = expected_q.pop_front();
                    if (current_value !== want.current)
                        note_mismatch("current_value", want.current, current_value);
                    if (voltage_value !== want.voltage)
                        note_mismatch("voltage_value", want.voltage, voltage_value);
                    if (power_value !== want.power)
                        note_mismatch("power_value", want.power, power_value);
                    if (period_zero !== want.pzero)
                        note_mismatch("period_zero", want.pzero, period_zero);
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic push_reading(input logic [RAW_W-1:0] irms, input logic [RAW_W-1:0] vrms,
                                input logic [PERIOD_W-1:0] period,
                                input logic [RAW_W-1:0] eraw);
        reading_t rd;
        rd.irms   = irms;
        rd.vrms   = vrms;
        rd.period = period;
        rd.eraw   = eraw;
        reading_q.push_back(rd);
        readings_queued++;
    endtask

    // Corner readings: zero energy, zero period, knee, full-scale energy
    task automatic push_corner_readings();
        push_reading('0, '0, '0, '0);
        push_reading('1, '1, '1, '1);
        push_reading('1, 24'd1000, 16'd100, '0);
        push_reading(24'd5000, 24'd7000, '0, 24'h12_3456);
        push_reading(24'h00_1234, 24'd200, 16'd1, 24'h7F_FFFF);
        push_reading(24'h00_4321, 24'd300, 16'd1, 24'h80_0000);
        push_reading(24'd77, VOLTAGE_KNEE - 24'd1, 16'd50, 24'd10);
        push_reading(24'd77, VOLTAGE_KNEE, 16'd50, 24'd10);
        push_reading(24'd1, '1, '1, 24'd1);
        push_reading(24'd2, 24'd3, 16'd3, '1);
        push_reading('1, '1, '1, 24'h40_0000);
        push_reading(24'd9, 24'd9, 16'd2, 24'hFF_FFF9);
    endtask

    function automatic logic [COEF_W-1:0] random_gain();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return $urandom_range(0, 32'h0004_0000);
    endfunction

    function automatic logic [COEF_W-1:0] random_signed_coef();
        if ($urandom_range(0, 3) == 0)
            return $urandom;
        return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
    endfunction

    task automatic push_random_reading();
        logic [RAW_W-1:0]    irms;
        logic [RAW_W-1:0]    vrms;
        logic [PERIOD_W-1:0] period;
        logic [RAW_W-1:0]    eraw;
        case ($urandom_range(0, 9))
            0:       irms = '0;
            1:       irms = '1;
            2, 3:    irms = $urandom_range(0, 255);
            default: irms = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0, 1:    vrms = VOLTAGE_KNEE + $urandom_range(0, 6) - 3;
            2:       vrms = '1;
            3:       vrms = '0;
            default: vrms = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0:       period = '0;
            1, 2:    period = $urandom_range(1, 15);
            3:       period = '1;
            default: period = $urandom;
        endcase
        case ($urandom_range(0, 9))
            0:       eraw = '0;
            1:
            begin
                case ($urandom_range(0, 3))
                    0:       eraw = 24'h80_0000;
                    1:       eraw = 24'h7F_FFFF;
                    2:       eraw = 24'hFF_FFFF;
                    default: eraw = 24'h00_0001;
                endcase
            end
            2, 3:    eraw = $urandom_range(0, 512) - 256;
            default: eraw = $urandom;
        endcase
        push_reading(irms, vrms, period, eraw);
    endtask

    // Write all eight registers back to back; block must be idle
    task automatic program_settings(input setting_style_e style);
        cfg_idx_e          idx;
        bit                gain_reg;
        logic [COEF_W-1:0] value;
        for (int i = 0; i < NUM_CFG; i++)
        begin
            idx      = cfg_idx_e'(i);
            gain_reg = (idx == CFG_CURRENT_GAIN) || (idx == CFG_VOLTAGE_GAIN_LOW)
                       || (idx == CFG_VOLTAGE_GAIN_HIGH);
            case (style)
                STYLE_RESET: value = CFG_RESET[i];
                STYLE_MAX:   value = gain_reg ? '1 : 32'h7FFF_FFFF;
                STYLE_MIN:   value = gain_reg ? '0 : 32'h8000_0000;
                default:     value = gain_reg ? random_gain() : random_signed_coef();
            endcase
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= value;
            do
                @(posedge clk);
            while (!cfg_ready);
            cfg_model[idx] = value;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (readings_accepted != readings_queued || expected_q.size() != 0);
    endtask

    // Idle mix: sender light / receiver heavy, then reversed, then none
    task automatic set_idling(input int mode);
        case (mode % 3)
            0:
            begin
                sender_idle_pct   = 8;
                receiver_idle_pct = 59;
            end
            1:
            begin
                sender_idle_pct   = 59;
                receiver_idle_pct = 8;
            end
            default:
            begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
        endcase
    endtask

    // Main sequence
    initial
    begin
        cfg_model = CFG_RESET;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // corner readings at reset coefficients, then at the minimum extremes
        set_idling(0);
        push_corner_readings();
        wait_idle();
        program_settings(STYLE_MIN);
        set_idling(1);
        push_corner_readings();
        wait_idle();

        // random readings, new coefficients each phase
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0:       program_settings(STYLE_MAX);
                4:       program_settings(STYLE_RESET);
                7:       program_settings(STYLE_MIN);
                default: program_settings(STYLE_RANDOM);
            endcase
            set_idling(phase);
            for (int n = 0; n < READINGS_PER_PHASE; n++)
                push_random_reading();
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_q.size() != 0)
        begin
            $display("%0d results never arrived", expected_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
